// File: hw/rtl/fdl_pkg.sv
// Shared constants and types of the feedback delay line.
`default_nettype none

package fdl_pkg;

  // Fixed field widths of the register map and the arithmetic
  localparam int DELAY_W = 14;
  localparam int GAIN_W  = 16;
  localparam int FRAC_W  = GAIN_W - 1;
  localparam int CCNT_W  = 2;

  // APB-style configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // Input hold-off after a register write while the delay modulo settles
  localparam int            SETTLE_W   = 2;
  localparam logic [SETTLE_W-1:0] CFG_SETTLE = 2'd2;

  // Result queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // Parameter defaults
  localparam int DEF_DEPTH_FRAMES = 16384;
  localparam int DEF_MAX_CHANNELS = 2;
  localparam int DEF_SAMPLE_BITS  = 16;

  typedef enum logic [1:0] {
    REG_DELAY = 2'd0,
    REG_GAIN  = 2'd1,
    REG_CHANS = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } fdl_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/fdl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module fdl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read during write to the same address returns the old content
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: hw/rtl/fdl_oq.sv
// Small result queue that decouples the processing pipeline from the receiver.
`default_nettype none

module fdl_oq
  import fdl_pkg::*;
#(
  parameter int WIDTH = 17,
  parameter int DEPTH = OQ_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [WIDTH-1:0]           out_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign count     = count_r;
  assign pop       = out_valid && !out_stall;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // The upstream credit check must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < CNT_W'(DEPTH)) || pop)
    else $error("result queue overflow");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not grow on push");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> count_r == $past(count_r) - 1'b1)
    else $error("queue count did not shrink on pop");

endmodule

`default_nettype wire

// File: hw/rtl/feedback_delay_line.sv
// Feedback comb delay line for interleaved audio, one sample per transaction.
//
// Input channel (in_valid/in_stall/in_sample_in) takes one Q1.15 sample of
// one channel per transaction; channels are interleaved, channel_count per
// frame. Output channel (out_valid/out_stall/out_sample_out/out_channel)
// returns the sample stored delay_frames frames earlier for that channel.
// The store is written back with input + feedback_gain * delayed, rounded
// and saturated. Registers sit on an APB-style port at byte addresses 0, 4, 8.
// An accepted sample passes the store read (v1_r) and the multiply stage
// (v2_r) and is pushed into the result queue before out_valid rises.
// Throughput: one sample per cycle while in_stall is low; when the read slot
// is still being written by one of the two previous samples (very short
// delays) the input is held until that write is done, set by the store
// read and the two-stage multiply/accumulate loop.
// Reset: the sample store is cleared by a pass over all DEPTH_FRAMES *
// 2^max(1, ceil(log2 MAX_CHANNELS)) entries (32768 at the defaults);
// in_stall stays high during it, register writes are taken. A register
// write holds the input while the delay modulo settles.
// A stalled receiver fills a four-entry result queue; the input stalls once
// four samples sit in the pipeline and the queue together.
`default_nettype none

module feedback_delay_line
  import fdl_pkg::*;
#(
  parameter int DEPTH_FRAMES = DEF_DEPTH_FRAMES,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_sample_in,
  // output channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] out_sample_out,
  output logic                   out_channel,
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_AW-1:0]      paddr,
  input  logic [CFG_DW-1:0]      pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready
);

  localparam int FRAME_W   = $clog2(DEPTH_FRAMES);
  localparam int CH_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ADDR_W    = FRAME_W + CH_W;
  localparam int RAM_DEPTH = DEPTH_FRAMES * (2 ** CH_W);
  localparam int CNT_W     = ($clog2(MAX_CHANNELS + 1) > CCNT_W) ?
                             $clog2(MAX_CHANNELS + 1) : CCNT_W;
  localparam int PROD_W    = SAMPLE_BITS + GAIN_W;
  localparam int ACC_W     = SAMPLE_BITS + GAIN_W + 1;
  localparam int RND_W     = SAMPLE_BITS + 2;
  localparam int MOD_W     = (FRAME_W > DELAY_W) ? FRAME_W : DELAY_W;
  localparam int INF_W     = OQ_CNT_W + 1;

  // delay % DEPTH_FRAMES by reciprocal multiplication, exact for 14-bit delays
  localparam int RSHIFT    = DELAY_W + FRAME_W;
  localparam int RECIP_W   = DELAY_W + 2;
  localparam int DM_PROD_W = DELAY_W + RECIP_W;
  localparam longint unsigned RECIP_L =
    ((64'd1 << RSHIFT) + 64'(DEPTH_FRAMES) - 64'd1) / 64'(DEPTH_FRAMES);
  localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_L);
  localparam logic [DELAY_W-1:0] DEPTH_LO = DELAY_W'(DEPTH_FRAMES % (2 ** DELAY_W));

  localparam logic [FRAME_W:0]        DEPTH_EXT  = (FRAME_W + 1)'(DEPTH_FRAMES);
  localparam logic [FRAME_W-1:0]      FRAME_LAST = FRAME_W'(DEPTH_FRAMES - 1);
  localparam logic [ADDR_W-1:0]       CLR_LAST   = ADDR_W'(RAM_DEPTH - 1);
  localparam logic signed [ACC_W-1:0] RND_HALF   = ACC_W'(2 ** (FRAC_W - 1));
  localparam logic [SAMPLE_BITS-1:0]  SAT_MAX    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0]  SAT_MIN    = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // ---------------------------------------------------------------- config
  logic                     cfg_wr;
  logic [DELAY_W-1:0]       delay_r;
  logic signed [GAIN_W-1:0] gain_r;
  logic [CCNT_W-1:0]        chans_r;
  logic [SETTLE_W-1:0]      hold_r;
  cfg_reg_t                 cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = cfg_reg_t'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= '0;
      gain_r  <= '0;
      chans_r <= CCNT_W'(1);
      hold_r  <= '0;
    end else begin
      if (cfg_wr) begin
        hold_r <= CFG_SETTLE;
        case (cfg_idx)
          REG_DELAY: delay_r <= pwdata[DELAY_W-1:0];
          REG_GAIN:  gain_r  <= pwdata[GAIN_W-1:0];
          REG_CHANS: chans_r <= pwdata[CCNT_W-1:0];
          default: ;
        endcase
      end else if (hold_r != '0) begin
        hold_r <= hold_r - 1'b1;
      end
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DELAY: prdata = CFG_DW'(delay_r);
      REG_GAIN:  prdata = CFG_DW'($unsigned(gain_r));
      REG_CHANS: prdata = CFG_DW'(chans_r);
      default:   prdata = '0;
    endcase
  end

  // two-stage delay modulo, settles within the post-write hold
  logic [DM_PROD_W-1:0] dm_prod_r;
  logic [DELAY_W-1:0]   dm_quot, dm_qd, dm_rem;
  logic [MOD_W-1:0]     dm_rem_ext;
  logic [FRAME_W-1:0]   dm_mod_r;

  assign dm_quot    = DELAY_W'(dm_prod_r >> RSHIFT);
  assign dm_qd      = DELAY_W'(dm_quot * DEPTH_LO);
  assign dm_rem     = delay_r - dm_qd;
  assign dm_rem_ext = MOD_W'(dm_rem);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dm_prod_r <= '0;
      dm_mod_r  <= '0;
    end else begin
      dm_prod_r <= DM_PROD_W'(delay_r) * DM_PROD_W'(RECIP);
      dm_mod_r  <= dm_rem_ext[FRAME_W-1:0];
    end
  end

  // ------------------------------------------------------ clear pass FSM
  fdl_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              clearing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    clearing     = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        clearing     = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == CLR_LAST) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: ;
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // ------------------------------------------------- position and address
  logic [FRAME_W-1:0] wf_r;
  logic [CH_W-1:0]    ch_r;
  logic [CNT_W-1:0]   cc_ext, chans_eff, ch_inc;
  logic               frame_end;
  logic [FRAME_W:0]   rd_diff, rd_wrap;
  logic [FRAME_W-1:0] rd_frame;
  logic [ADDR_W-1:0]  ri, wi;

  assign cc_ext    = CNT_W'(chans_r);
  assign chans_eff = (cc_ext == '0) ? CNT_W'(1) :
                     (cc_ext > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS) : cc_ext;
  assign ch_inc    = CNT_W'(ch_r) + 1'b1;
  assign frame_end = (ch_inc >= chans_eff);

  assign rd_diff  = {1'b0, wf_r} - {1'b0, dm_mod_r};
  assign rd_wrap  = rd_diff + DEPTH_EXT;
  assign rd_frame = rd_diff[FRAME_W] ? rd_wrap[FRAME_W-1:0] : rd_diff[FRAME_W-1:0];
  assign ri       = {rd_frame, ch_r};
  assign wi       = {wf_r, ch_r};

  // ------------------------------------------------------------- pipeline
  logic                          v1_r, v2_r;
  logic [SAMPLE_BITS-1:0]        x1_r, x2_r;
  logic [ADDR_W-1:0]             wi1_r, wi2_r;
  logic                          self1_r, self2_r;
  logic                          ch1_r, ch2_r;
  logic signed [SAMPLE_BITS-1:0] dly2_r;
  logic signed [PROD_W-1:0]      prod2_r;
  logic signed [SAMPLE_BITS-1:0] ram_rdata;
  logic signed [PROD_W-1:0]      prod_s;
  logic [OQ_CNT_W-1:0]           oq_count;
  logic [INF_W-1:0]              inflight;
  logic                          hazard, in_accept;

  // a slot still being written by either earlier sample cannot be read yet
  assign hazard    = (v1_r && (wi1_r == ri)) || (v2_r && (wi2_r == ri));
  assign inflight  = INF_W'(v1_r) + INF_W'(v2_r) + INF_W'(oq_count);
  assign in_stall  = clearing || cfg_wr || (hold_r != '0) || hazard ||
                     (inflight >= INF_W'(OQ_DEPTH));
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wf_r <= '0;
      ch_r <= '0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_accept;
      v2_r <= v1_r;
      if (in_accept) begin
        if (frame_end) begin
          ch_r <= '0;
          wf_r <= (wf_r == FRAME_LAST) ? '0 : wf_r + 1'b1;
        end else begin
          ch_r <= ch_inc[CH_W-1:0];
        end
      end
    end
  end

  assign prod_s = gain_r * ram_rdata;

  always_ff @(posedge clk) begin
    x1_r    <= in_sample_in;
    wi1_r   <= wi;
    self1_r <= (ri == wi);
    ch1_r   <= ch_r[0];
    x2_r    <= x1_r;
    wi2_r   <= wi1_r;
    self2_r <= self1_r;
    ch2_r   <= ch1_r;
    dly2_r  <= ram_rdata;
    prod2_r <= prod_s;
  end

  // stage 2: accumulate, round half up, saturate
  logic signed [ACC_W-1:0]  x_ext, p_ext, acc;
  logic [RND_W-1:0]         rnd;
  logic [SAMPLE_BITS-1:0]   nv, result;
  logic                     in_range;

  assign x_ext    = {{2{x2_r[SAMPLE_BITS-1]}}, x2_r, {FRAC_W{1'b0}}};
  assign p_ext    = {prod2_r[PROD_W-1], prod2_r};
  assign acc      = x_ext + p_ext + RND_HALF;
  assign rnd      = acc[ACC_W-1:FRAC_W];
  assign in_range = (rnd[RND_W-1:SAMPLE_BITS-1] == '0) ||
                    (rnd[RND_W-1:SAMPLE_BITS-1] == '1);
  assign nv       = in_range ? rnd[SAMPLE_BITS-1:0] :
                    (rnd[RND_W-1] ? SAT_MIN : SAT_MAX);
  // zero delay returns the freshly written value
  assign result   = self2_r ? nv : dly2_r;

  fdl_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (clearing || v2_r),
    .waddr (clearing ? clr_addr_r : wi2_r),
    .wdata (clearing ? '0 : nv),
    .re    (in_accept),
    .raddr (ri),
    .rdata (ram_rdata)
  );

  fdl_oq #(
    .WIDTH (SAMPLE_BITS + 1),
    .DEPTH (OQ_DEPTH)
  ) u_oq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (v2_r),
    .push_data ({result, ch2_r}),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  ({out_sample_out, out_channel}),
    .count     (oq_count)
  );

  // ----------------------------------------------------------- assertions
  a_no_item_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !v1_r && !v2_r)
    else $error("sample in flight during store clear");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inflight <= INF_W'(OQ_DEPTH))
    else $error("more transactions in flight than queue entries");

  a_pipe_advance: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> v1_r ##1 v2_r)
    else $error("accepted sample did not reach write stage");

  a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> in_stall ##1 in_stall)
    else $error("input taken before delay modulo settled");

endmodule

`default_nettype wire
